/* src/line_rasterizer_with_pixel_address_macros.svh */
// Assertion macros for the line rasterizer.
// Depends on clk and arst_n being visible at the point of use.
`ifndef LINE_RASTERIZER_WITH_PIXEL_ADDRESS_MACROS_SVH
`define LINE_RASTERIZER_WITH_PIXEL_ADDRESS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LRPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrpa assertion failed");
// Next-cycle implication, checked out of reset.
`define LRPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrpa assertion failed");
`else
`define LRPA_ASSERT_NOW(label, ante, cons)
`define LRPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/lrpa_pkg.sv */
// Shared constants and codes for the line rasterizer.
// No dependencies.
package lrpa_pkg;

	localparam int CoordBitsDefault = 12;
	localparam int ChanBits         = 8;
	localparam int ColorBits        = 32;
	localparam int AddrBits         = 28;
	localparam int OffsetBits       = 5;
	localparam int BppBits          = 3;
	localparam int StrideBits       = 16;
	localparam int CfgDataBits      = 16;
	localparam int CfgIndexBits     = 3;

	// Configuration register indexes.
	typedef enum logic [CfgIndexBits-1:0] {
		CfgRedOffset   = 3'd0,
		CfgGreenOffset = 3'd1,
		CfgBlueOffset  = 3'd2,
		CfgAlphaOffset = 3'd3,
		CfgBytesPerPix = 3'd4,
		CfgLineStride  = 3'd5
	} cfg_index_t;

	// Request codes.
	typedef enum logic {
		ReqStart = 1'b0,
		ReqStep  = 1'b1
	} req_type_t;

	// Register reset values.
	localparam logic [OffsetBits-1:0] RedOffsetReset   = 5'd16;
	localparam logic [OffsetBits-1:0] GreenOffsetReset = 5'd8;
	localparam logic [OffsetBits-1:0] BlueOffsetReset  = 5'd0;
	localparam logic [OffsetBits-1:0] AlphaOffsetReset = 5'd24;
	localparam logic [BppBits-1:0]    BppReset         = 3'd4;
	localparam logic [StrideBits-1:0] StrideReset      = 16'd4096;

endpackage

/* src/lrpa_req_if.sv */
// Request channel of the line rasterizer: valid, ready and one request beat.
// Depends on lrpa_pkg for the default coordinate width and channel width.
interface lrpa_req_if #(
	parameter int COORD_BITS = lrpa_pkg::CoordBitsDefault
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [COORD_BITS-1:0]         start_x;
	logic [COORD_BITS-1:0]         start_y;
	logic [COORD_BITS-1:0]         end_x;
	logic [COORD_BITS-1:0]         end_y;
	logic [lrpa_pkg::ChanBits-1:0] red;
	logic [lrpa_pkg::ChanBits-1:0] green;
	logic [lrpa_pkg::ChanBits-1:0] blue;
	logic [lrpa_pkg::ChanBits-1:0] alpha;

	modport source (
		output valid, req_type, start_x, start_y, end_x, end_y, red, green, blue, alpha,
		input  ready
	);
	modport sink (
		input  valid, req_type, start_x, start_y, end_x, end_y, red, green, blue, alpha,
		output ready
	);
endinterface

// Pixel result channel: valid, ready and one pixel beat.
interface lrpa_pix_if #(
	parameter int COORD_BITS = lrpa_pkg::CoordBitsDefault
);
	logic                           valid;
	logic                           ready;
	logic                           pixel_valid;
	logic [COORD_BITS-1:0]          pixel_x;
	logic [COORD_BITS-1:0]          pixel_y;
	logic [lrpa_pkg::AddrBits-1:0]  pixel_address;
	logic [lrpa_pkg::ColorBits-1:0] pixel_color;
	logic                           last_pixel;

	modport source (
		output valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		output ready
	);
endinterface

/* src/line_rasterizer_with_pixel_address.sv */
// Bresenham line rasterizer: one pixel result beat per request beat.
// Two register stages: an accepted request beat is registered in stage one, then in stage
// two, which drives the result beat. Throughput: one request per cycle unless pix.ready
// stalls; the line step is decided at accept and the byte address multiply runs in the
// second stage. Reset clears the line state, the stage valid flags and the registers to
// their documented values. Depends on lrpa_pkg and the macros.
`include "line_rasterizer_with_pixel_address_macros.svh"

module line_rasterizer_with_pixel_address #(
	parameter int COORD_BITS = lrpa_pkg::CoordBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lrpa_pkg::CfgIndexBits-1:0] cfg_index,
	input  logic [lrpa_pkg::CfgDataBits-1:0]  cfg_data,
	lrpa_req_if.sink                          req,
	lrpa_pix_if.source                        pix
);
	import lrpa_pkg::*;

	localparam int ErrBits = COORD_BITS + 2;
	localparam int ProdBits = COORD_BITS + StrideBits + 1;
	localparam int SumBits = (ProdBits > AddrBits) ? ProdBits : AddrBits;

	// Configuration registers.
	logic [OffsetBits-1:0] red_off_q, green_off_q, blue_off_q, alpha_off_q;
	logic [BppBits-1:0]    bpp_q;
	logic [StrideBits-1:0] stride_q;

	// Line state.
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic [COORD_BITS-1:0] delta_x_q, delta_y_q;
	logic                  step_x_neg_q, step_y_neg_q;
	logic signed [ErrBits-1:0] err_q;
	logic                  line_active_q;
	logic [ColorBits-1:0]  color_q;

	// Next line state.
	logic [COORD_BITS-1:0] nx_cur_x, nx_cur_y, nx_target_x, nx_target_y;
	logic [COORD_BITS-1:0] nx_delta_x, nx_delta_y;
	logic                  nx_step_x_neg, nx_step_y_neg;
	logic signed [ErrBits-1:0] nx_err;
	logic                  nx_line_active;
	logic [ColorBits-1:0]  nx_color;
	logic                  res_pixel_valid, res_last;

	// Pipeline stages.
	logic                  v_s1, v_s2;
	logic                  pixel_valid_s1, last_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [ColorBits-1:0]  color_s1;
	logic                  pixel_valid_s2, last_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [ColorBits-1:0]  color_s2;
	logic [AddrBits-1:0]   addr_s2;

	logic ready_s1, ready_s2, in_fire;
	logic [SumBits-1:0] addr_sum;

	// Handshake: each stage moves when the one after it has room.
	assign ready_s2 = !v_s2 || pix.ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign req.ready = ready_s1;
	assign in_fire = req.valid && ready_s1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_off_q   <= RedOffsetReset;
			green_off_q <= GreenOffsetReset;
			blue_off_q  <= BlueOffsetReset;
			alpha_off_q <= AlphaOffsetReset;
			bpp_q       <= BppReset;
			stride_q    <= StrideReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgRedOffset:   red_off_q   <= cfg_data[OffsetBits-1:0];
				CfgGreenOffset: green_off_q <= cfg_data[OffsetBits-1:0];
				CfgBlueOffset:  blue_off_q  <= cfg_data[OffsetBits-1:0];
				CfgAlphaOffset: alpha_off_q <= cfg_data[OffsetBits-1:0];
				CfgBytesPerPix: bpp_q       <= cfg_data[BppBits-1:0];
				CfgLineStride:  stride_q    <= cfg_data[StrideBits-1:0];
				default: ;
			endcase
		end
	end

	// Line setup on start, one Bresenham step on advance.
	always_comb begin
		logic sx_lt, sy_lt, go_x, go_y;
		logic [COORD_BITS-1:0] dx, dy;
		logic signed [ErrBits-1:0] dx_ext, dy_ext, err_tmp;

		nx_cur_x = cur_x_q;
		nx_cur_y = cur_y_q;
		nx_target_x = target_x_q;
		nx_target_y = target_y_q;
		nx_delta_x = delta_x_q;
		nx_delta_y = delta_y_q;
		nx_step_x_neg = step_x_neg_q;
		nx_step_y_neg = step_y_neg_q;
		nx_err = err_q;
		nx_color = color_q;
		res_pixel_valid = 1'b0;

		sx_lt = req.start_x < req.end_x;
		sy_lt = req.start_y < req.end_y;
		dx = sx_lt ? req.end_x - req.start_x : req.start_x - req.end_x;
		dy = sy_lt ? req.end_y - req.start_y : req.start_y - req.end_y;

		dx_ext = $signed({2'b00, delta_x_q});
		dy_ext = $signed({2'b00, delta_y_q});
		go_x = err_q > -dx_ext;
		go_y = err_q < dy_ext;
		err_tmp = err_q;

		if (req.req_type == ReqStart) begin
			res_pixel_valid = 1'b1;
			nx_cur_x = req.start_x;
			nx_cur_y = req.start_y;
			nx_target_x = req.end_x;
			nx_target_y = req.end_y;
			nx_delta_x = dx;
			nx_delta_y = dy;
			nx_step_x_neg = !sx_lt;
			nx_step_y_neg = !sy_lt;
			if (dx > dy) begin
				nx_err = $signed({3'b000, dx[COORD_BITS-1:1]});
			end else begin
				nx_err = -$signed({3'b000, dy[COORD_BITS-1:1]});
			end
			nx_color = (ColorBits'(req.red) << red_off_q)
				| (ColorBits'(req.green) << green_off_q)
				| (ColorBits'(req.blue) << blue_off_q)
				| (ColorBits'(req.alpha) << alpha_off_q);
		end else if (line_active_q) begin
			res_pixel_valid = 1'b1;
			if (go_x) begin
				err_tmp = err_tmp - dy_ext;
				nx_cur_x = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
			end
			if (go_y) begin
				err_tmp = err_tmp + dx_ext;
				nx_cur_y = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
			nx_err = err_tmp;
		end

		res_last = res_pixel_valid && (nx_cur_x == nx_target_x) && (nx_cur_y == nx_target_y);
		nx_line_active = res_pixel_valid ? !res_last : line_active_q;
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q <= '0;
			line_active_q <= 1'b0;
			color_q <= '0;
		end else if (in_fire) begin
			cur_x_q <= nx_cur_x;
			cur_y_q <= nx_cur_y;
			target_x_q <= nx_target_x;
			target_y_q <= nx_target_y;
			delta_x_q <= nx_delta_x;
			delta_y_q <= nx_delta_y;
			step_x_neg_q <= nx_step_x_neg;
			step_y_neg_q <= nx_step_y_neg;
			err_q <= nx_err;
			line_active_q <= nx_line_active;
			color_q <= nx_color;
		end
	end

	// Stage one holds the pixel, zeroed when an advance finds no line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_valid_s1 <= res_pixel_valid;
			last_s1 <= res_last;
			x_s1 <= res_pixel_valid ? nx_cur_x : '0;
			y_s1 <= res_pixel_valid ? nx_cur_y : '0;
			color_s1 <= res_pixel_valid ? nx_color : '0;
		end
	end

	// Stage two adds the byte address.
	assign addr_sum = SumBits'(x_s1) * SumBits'(bpp_q) + SumBits'(y_s1) * SumBits'(stride_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			pixel_valid_s2 <= pixel_valid_s1;
			last_s2 <= last_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			color_s2 <= color_s1;
			addr_s2 <= addr_sum[AddrBits-1:0];
		end
	end

	assign pix.valid = v_s2;
	assign pix.pixel_valid = pixel_valid_s2;
	assign pix.pixel_x = x_s2;
	assign pix.pixel_y = y_s2;
	assign pix.pixel_address = addr_s2;
	assign pix.pixel_color = color_s2;
	assign pix.last_pixel = last_s2;

	// An empty result beat carries only zeros.
	`LRPA_ASSERT_NOW(a_empty_zero, v_s2 && !pixel_valid_s2, addr_s2 == '0 && color_s2 == '0 && x_s2 == '0 && y_s2 == '0 && !last_s2)
	// The last flag only rides on a real pixel.
	`LRPA_ASSERT_NOW(a_last_is_pixel, v_s2 && last_s2, pixel_valid_s2)
	// An advance with no line in progress leaves the line state alone.
	`LRPA_ASSERT_NEXT(a_idle_step_hold, in_fire && req.req_type == ReqStep && !line_active_q, $stable(cur_x_q) && $stable(cur_y_q) && $stable(err_q) && !line_active_q)
	// Requests stall only when both stages are full.
	`LRPA_ASSERT_NOW(a_stall_full, !req.ready, v_s1 && v_s2 && !pix.ready)

endmodule
